@@ rtl/core/vcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// vcfb_pkg: shared types and constants of the VTX command frame builder
// Item and result formats, the queued command descriptor, frame constants
// and the CRC-8/DVB-S2 byte update.
// ----------------------------------------------------------------------------
package vcfb_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_CHANNEL = 2'd0;
    localparam logic [1:0] OP_POWER   = 2'd1;
    localparam logic [1:0] OP_FREQ    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Frame constants
    localparam logic [7:0]  SYNC1       = 8'hAA;
    localparam logic [7:0]  SYNC2       = 8'h55;
    localparam logic [7:0]  CMD_CHANNEL = 8'h07;
    localparam logic [7:0]  CMD_POWER   = 8'h05;
    localparam logic [7:0]  CMD_FREQ    = 8'h09;
    localparam logic [15:0] FREQ_MASK   = 16'h3FFF;
    localparam logic [15:0] PIT_BIT     = 16'h8000;
    localparam logic [7:0]  CRC_POLY    = 8'hD5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  band;
        logic [7:0]  channel;
        logic [7:0]  power_level;
        logic [15:0] frequency_mhz;
        logic        pit_mode_flag;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_result;

    // One classified command: payload is one byte (pay0) or two (pay0, pay1)
    typedef struct packed {
        logic       two_byte;
        logic [7:0] cmd;
        logic [7:0] pay0;
        logic [7:0] pay1;
    } t_cmd_desc;

    typedef struct packed {
        logic      valid;
        t_cmd_desc desc;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // CRC-8/DVB-S2, MSB first, one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/vcfb_front.sv @@
// ----------------------------------------------------------------------------
// vcfb_front: item intake and command classification
// Accepts items, decodes the opcode into a command descriptor and holds it
// in one register until the command queue takes it. Unused opcodes are dropped.
// ----------------------------------------------------------------------------
module vcfb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  vcfb_pkg::t_item    i_item,
    input  vcfb_pkg::t_q_status i_q_status,
    output vcfb_pkg::t_q_wr    o_q_wr
);
    import vcfb_pkg::*;

    logic      r_valid;
    t_cmd_desc r_desc;
    t_cmd_desc n_desc;
    logic      n_keep;
    logic      take;
    logic [15:0] freq_word;

    assign full = r_valid & i_q_status.full;
    assign take = push & ~full;

    assign freq_word = (i_item.frequency_mhz & FREQ_MASK) |
                       (i_item.pit_mode_flag ? PIT_BIT : 16'h0000);

    always_comb begin
        n_desc = '0;
        n_keep = 1'b1;
        unique case (i_item.opcode)
            OP_CHANNEL: begin
                n_desc.two_byte = 1'b1;
                n_desc.cmd      = CMD_CHANNEL;
                n_desc.pay0     = i_item.band;
                n_desc.pay1     = i_item.channel;
            end
            OP_POWER: begin
                n_desc.two_byte = 1'b0;
                n_desc.cmd      = CMD_POWER;
                n_desc.pay0     = i_item.power_level;
            end
            OP_FREQ: begin
                n_desc.two_byte = 1'b1;
                n_desc.cmd      = CMD_FREQ;
                n_desc.pay0     = freq_word[15:8];
                n_desc.pay1     = freq_word[7:0];
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= n_keep;
        end else if (r_valid && !i_q_status.full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_desc <= n_desc;
        end
    end

    assign o_q_wr.valid = r_valid;
    assign o_q_wr.desc  = r_desc;

endmodule

@@ rtl/core/vcfb_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// vcfb_cmd_queue: command descriptor queue
// Small circular queue between the front end and the frame serializer.
// The head entry is shown while the queue is not empty.
// ----------------------------------------------------------------------------
module vcfb_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vcfb_pkg::t_q_wr      i_wr,
    input  logic                 i_rd,
    output vcfb_pkg::t_cmd_desc  o_head,
    output vcfb_pkg::t_q_status  o_status
);
    import vcfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd_desc       r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en;
    logic            rd_en;
    logic            is_full;
    logic            is_empty;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign wr_en    = i_wr.valid & ~is_full;
    assign rd_en    = i_rd & ~is_empty;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr.desc;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = is_full;
    assign o_status.empty = is_empty;

endmodule

@@ rtl/core/vcfb_back.sv @@
// ----------------------------------------------------------------------------
// vcfb_back: frame serializer
// Walks one command frame a byte per cycle unless pop holds the output, runs
// the CRC over length, command and payload, and presents bytes through an output register.
// ----------------------------------------------------------------------------
module vcfb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vcfb_pkg::t_cmd_desc  i_head,
    input  vcfb_pkg::t_q_status  i_q_status,
    output logic                 o_q_pop,
    output logic                 empty,
    input  logic                 pop,
    output vcfb_pkg::t_result    o_result
);
    import vcfb_pkg::*;

    // Byte positions within a frame
    localparam logic [2:0] BYTE_SYNC1     = 3'd0;
    localparam logic [2:0] BYTE_SYNC2     = 3'd1;
    localparam logic [2:0] BYTE_LEN       = 3'd2;
    localparam logic [2:0] BYTE_CMD       = 3'd3;
    localparam logic [2:0] BYTE_PAY0      = 3'd4;
    localparam logic [2:0] BYTE_PAY1      = 3'd5;
    localparam logic [2:0] BYTE_CRC_LONG  = 3'd6;

    logic       r_busy;
    t_cmd_desc  r_desc;
    logic [2:0] r_idx;
    logic [7:0] r_crc;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       cur_valid;
    t_cmd_desc  cur;
    logic [2:0] cur_idx;
    logic [7:0] cur_crc;
    logic [7:0] data_byte;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic [2:0] last_idx;
    logic [7:0] n_crc;

    assign advance   = ~r_out_valid | pop;
    assign cur_valid = r_busy | ~i_q_status.empty;
    assign cur       = r_busy ? r_desc : i_head;
    assign cur_idx   = r_busy ? r_idx : BYTE_SYNC1;
    assign cur_crc   = r_busy ? r_crc : 8'h00;
    assign last_idx  = cur.two_byte ? BYTE_CRC_LONG : BYTE_PAY1;
    assign emit_last = (cur_idx == last_idx);

    always_comb begin
        case (cur_idx)
            BYTE_SYNC1: data_byte = SYNC1;
            BYTE_SYNC2: data_byte = SYNC2;
            BYTE_LEN:   data_byte = {6'd0, cur.two_byte, ~cur.two_byte};
            BYTE_CMD:   data_byte = cur.cmd;
            BYTE_PAY0:  data_byte = cur.pay0;
            BYTE_PAY1:  data_byte = cur.pay1;
            default:    data_byte = 8'h00;
        endcase
    end

    assign emit_byte = emit_last ? cur_crc : data_byte;
    // CRC starts at the length byte; sync bytes leave it at zero
    assign n_crc = (cur_idx >= BYTE_LEN) ? crc8_feed(cur_crc, data_byte) : cur_crc;

    assign o_q_pop = advance & ~r_busy & ~i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= cur_valid;
            if (cur_valid) begin
                r_busy <= ~emit_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && cur_valid) begin
            r_desc          <= cur;
            r_idx           <= cur_idx + 1'b1;
            r_crc           <= n_crc;
            r_out.out_byte  <= emit_byte;
            r_out.last_byte <= emit_last;
        end
    end

    assign empty    = ~r_out_valid;
    assign o_result = r_out;

endmodule

@@ rtl/core/vtx_command_frame_builder_top.sv @@
// ----------------------------------------------------------------------------
// vtx_command_frame_builder_top: VTX command frame builder
// Turns video-transmitter commands into SmartAudio-style byte frames
// closed by a CRC-8/DVB-S2 byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_item and raise push; the item is taken at a rising
//   edge with push high and full low. Opcode 3 items are taken and dropped.
//   Result channel: while empty is low, o_result holds the oldest frame byte;
//   raise pop to take it. last_byte marks the CRC byte that closes a frame.
//   Frame: AA 55 len cmd payload crc, 6 bytes for set power, 7 otherwise.
//   Path: an item passes the front register, the command queue and the
//   output register of the serializer before its first byte shows.
//   Throughput: one byte per cycle while pop is high, 6 or 7 bytes per item;
//   the byte serializer in the back end sets this. Frames follow each other
//   without gaps, and the front end keeps taking items until the command
//   queue (QUEUE_DEPTH entries plus one front register) fills.
//   Reset: synchronous, active low; clears all queues, no byte pending.
//   Stall: with pop low the current byte holds, the serializer pauses, and
//   full rises once the queue and the front register are occupied.
// ----------------------------------------------------------------------------
module vtx_command_frame_builder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  vcfb_pkg::t_item    i_item,
    output logic               empty,
    input  logic               pop,
    output vcfb_pkg::t_result  o_result
);
    import vcfb_pkg::*;

    t_q_wr     q_wr;
    t_q_status q_status;
    t_cmd_desc q_head;
    logic      q_pop;

    // Classify items and hold one descriptor for the queue
    vcfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_q_wr     (q_wr)
    );

    // Decouple intake from byte emission
    vcfb_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_rd     (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // Serialize frames and compute the CRC
    vcfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

`ifndef SYNTH
    // An unused opcode never leaves a descriptor in the front register
    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_item.opcode == OP_UNUSED) |=> !q_wr.valid)
        else $error("unused opcode reached the command queue");

    // Queue entries leave only through the serializer
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_status.empty && !q_pop) |=> !q_status.empty)
        else $error("command queue lost an entry");

    // Full and empty exclude each other
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_status.empty)
        else $error("command queue full and empty at once");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the VTX command frame builder
// Offers command items through the push/full side and takes frame bytes
// through the empty/pop side. Random gaps are inserted on both sides, and
// the receiver holds off once for a long stretch so the command queue fills.
// Every accepted byte is compared with a frame computed in the bench. A short
// directed table, partly with hand-written frames, comes first, then random commands.
// ----------------------------------------------------------------------------
module tb_top;

    import vcfb_pkg::*;

    // Idle cycles with no handshake on either side before the run is aborted.
    // The slowest legal stall is the long receiver hold plus a sender gap.
    localparam int STUCK_LIMIT   = 2000;
    // Cycles to let pass after the last expected byte; covers the front-end
    // latency of a trailing unused-opcode item.
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 290;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 120;

    // One row of the directed table. With has_frame set, the expected frame
    // is typed in (frame_len bytes, first byte in the top bits); otherwise
    // the expected frame comes from the predictor.
    typedef struct packed {
        t_item       item;
        logic        has_frame;
        logic [3:0]  frame_len;
        logic [55:0] frame;
    } t_cmd_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_item     i_item;
    logic      empty;
    logic      pop;
    t_result   o_result;

    // Side information that travels with the item being offered
    logic        cur_has_frame;
    logic [3:0]  cur_frame_len;
    logic [55:0] cur_frame;

    t_result     frame_bytes_q[$];
    t_cmd_row    cmd_rows[$];
    int          err_cnt;
    int          stuck_cycles;
    int          bytes_popped;

    vtx_command_frame_builder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // CRC-8/DVB-S2, processed one message bit at a time
    function automatic logic [7:0] crc8_dvb_s2_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ b[k];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Append the bytes of the frame that one command produces
    function automatic void queue_frame_bytes(input t_item it);
        logic [7:0]  body [4];
        logic [15:0] freq_word;
        logic [7:0]  crc;
        int          n_body;
        n_body = 0;
        case (it.opcode)
            OP_CHANNEL: begin
                body[0] = 8'd2;
                body[1] = CMD_CHANNEL;
                body[2] = it.band;
                body[3] = it.channel;
                n_body  = 4;
            end
            OP_POWER: begin
                body[0] = 8'd1;
                body[1] = CMD_POWER;
                body[2] = it.power_level;
                n_body  = 3;
            end
            OP_FREQ: begin
                // Keep 14 bits of frequency; bit 14 always goes out as zero
                freq_word = (it.frequency_mhz & FREQ_MASK) |
                            (it.pit_mode_flag ? PIT_BIT : 16'h0000);
                body[0] = 8'd2;
                body[1] = CMD_FREQ;
                body[2] = freq_word[15:8];
                body[3] = freq_word[7:0];
                n_body  = 4;
            end
            default: begin
                n_body = 0;
            end
        endcase
        // Drop the unused opcode: no frame at all
        if (n_body == 0) begin
            return;
        end
        frame_bytes_q.push_back('{out_byte: SYNC1, last_byte: 1'b0});
        frame_bytes_q.push_back('{out_byte: SYNC2, last_byte: 1'b0});
        crc = 8'h00;
        for (int i = 0; i < n_body; i++) begin
            frame_bytes_q.push_back('{out_byte: body[i], last_byte: 1'b0});
            crc = crc8_dvb_s2_byte(crc, body[i]);
        end
        frame_bytes_q.push_back('{out_byte: crc, last_byte: 1'b1});
    endfunction

    function automatic t_item mk_item(input logic [1:0] op, input logic [7:0] band,
                                      input logic [7:0] chan, input logic [7:0] pwr,
                                      input logic [15:0] freq, input logic pit);
        t_item it;
        it.opcode        = op;
        it.band          = band;
        it.channel       = chan;
        it.power_level   = pwr;
        it.frequency_mhz = freq;
        it.pit_mode_flag = pit;
        return it;
    endfunction

    // Mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the rising edge in one process,
    // so an item's expected bytes are queued before any byte is checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                if (cur_has_frame) begin
                    for (int i = 0; i < cur_frame_len; i++) begin
                        frame_bytes_q.push_back('{out_byte: cur_frame[55 - 8 * i -: 8],
                                                  last_byte: (i == cur_frame_len - 1)});
                    end
                end else begin
                    queue_frame_bytes(i_item);
                end
            end
            if (pop && !empty) begin
                bytes_popped++;
                if (frame_bytes_q.size() == 0) begin
                    $error("unexpected byte %02h (last_byte %0b)",
                           o_result.out_byte, o_result.last_byte);
                    err_cnt++;
                end else begin
                    if (o_result.out_byte !== frame_bytes_q[0].out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               frame_bytes_q[0].out_byte, o_result.out_byte);
                        err_cnt++;
                    end
                    if (o_result.last_byte !== frame_bytes_q[0].last_byte) begin
                        $error("last_byte: expected %0b, actual %0b",
                               frame_bytes_q[0].last_byte, o_result.last_byte);
                        err_cnt++;
                    end
                    void'(frame_bytes_q.pop_front());
                end
            end
            // Count cycles with no handshake on either side
            if ((push && !full) || (pop && !empty)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
    end

    // Abort when nothing moves for too long
    initial begin
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: alternate stalls and pop runs; hold off once for a long
    // stretch so that the queue fills and full rises while items keep coming.
    // ------------------------------------------------------------------------
    initial begin
        int  stall;
        int  run;
        bit  held_long;
        pop       = 1'b0;
        held_long = 1'b0;
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            if (!held_long && bytes_popped >= HOLD_AFTER) begin
                held_long = 1'b1;
                pop       = 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) begin
                    @(negedge i_clk);
                end
            end
            stall = pick_gap();
            if (stall != 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            run = $urandom_range(1, 24);
            pop = 1'b1;
            repeat (run) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one item after a random gap and hold it until it is taken.
    // Push stays high into the next item when no gap follows.
    task automatic offer_item(input t_cmd_row row);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item        = row.item;
        cur_has_frame = row.has_frame;
        cur_frame_len = row.frame_len;
        cur_frame     = row.frame;
        push          = 1'b1;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin
        t_cmd_row row;
        t_item    it;
        int       n_valid;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_item        = '0;
        cur_has_frame = 1'b0;
        cur_frame_len = '0;
        cur_frame     = '0;
        err_cnt       = 0;
        stuck_cycles  = 0;
        bytes_popped  = 0;

        // Directed table. Typed frames: set power to zero, and the unused
        // opcode, which yields no bytes at all.
        cmd_rows.push_back('{mk_item(OP_POWER, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                             1'b1, 4'd6, 56'hAA_55_01_05_00_A4_00});
        cmd_rows.push_back('{mk_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1),
                             1'b1, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                             1'b1, 4'd0, 56'h0});
        // Set band and channel: extremes, and unused fields driven high
        cmd_rows.push_back('{mk_item(OP_CHANNEL, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_CHANNEL, 8'hFF, 8'hFF, 8'h00, 16'h0000, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_CHANNEL, 8'hFF, 8'h00, 8'hFF, 16'hFFFF, 1'b1),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_CHANNEL, 8'h00, 8'hFF, 8'hA5, 16'h5A5A, 1'b0),
                             1'b0, 4'd0, 56'h0});
        // Set power: extremes, and unused fields driven high
        cmd_rows.push_back('{mk_item(OP_POWER, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_POWER, 8'h00, 8'h00, 8'h80, 16'h0000, 1'b0),
                             1'b0, 4'd0, 56'h0});
        // Set frequency: zero, all ones, masked bit 14, pit mode
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'h3FFF, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'h4000, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'hC000, 1'b1),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_FREQ, 8'h00, 8'h00, 8'h00, 16'd5800, 1'b1),
                             1'b0, 4'd0, 56'h0});
        // Unused opcode squeezed between two real commands
        cmd_rows.push_back('{mk_item(OP_UNUSED, 8'h12, 8'h34, 8'h56, 16'h789A, 1'b0),
                             1'b0, 4'd0, 56'h0});
        cmd_rows.push_back('{mk_item(OP_POWER, 8'h00, 8'h00, 8'h7F, 16'h0000, 1'b0),
                             1'b0, 4'd0, 56'h0});

        // Hold reset, then release it at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (cmd_rows[i]) begin
            offer_item(cmd_rows[i]);
        end

        // Random commands; unused opcodes are sprinkled in but not counted
        n_valid = 0;
        while (n_valid < RANDOM_ITEMS) begin
            it.opcode = ($urandom_range(0, 19) == 0) ? OP_UNUSED :
                        2'($urandom_range(0, 2));
            it.band          = 8'($urandom);
            it.channel       = 8'($urandom);
            it.power_level   = 8'($urandom);
            it.frequency_mhz = ($urandom_range(0, 3) == 0) ?
                               16'($urandom_range(5000, 6000)) : 16'($urandom);
            it.pit_mode_flag = 1'($urandom);
            row = '{it, 1'b0, 4'd0, 56'h0};
            offer_item(row);
            if (it.opcode != OP_UNUSED) begin
                n_valid++;
            end
        end
        push = 1'b0;

        // Drain: wait for every expected byte, then let stragglers show up
        while (frame_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
